// ----- design/biou_pkg.sv -----
// Package for the box intersection-over-union unit: widths, stage payload
// types and the clamped-span helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package biou_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int UNION_BITS = AREA_BITS + 1;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int DIV_STAGES = FRAC_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AREA_BITS-1:0]  area_t;
    typedef logic [UNION_BITS-1:0] union_t;
    typedef logic [RATIO_BITS-1:0] ratio_t;

    // Clamped widths and heights
    typedef struct packed {
        coord_t iw;
        coord_t ih;
        coord_t wa;
        coord_t ha;
        coord_t wb;
        coord_t hb;
    } span_set_t;

    // Intersection and both box areas
    typedef struct packed {
        area_t inter;
        area_t area_a;
        area_t area_b;
    } area_set_t;

    // Divider operands as they leave the front end
    typedef struct packed {
        area_t  inter;
        union_t uni;
        logic   empty;
    } div_operand_t;

    // Partial state inside the divider pipeline
    typedef struct packed {
        union_t rem;
        ratio_t quot;
        union_t uni;
        logic   empty;
    } div_state_t;

    // Finished quotient handed to the output register
    typedef struct packed {
        ratio_t quot;
        logic   empty;
    } div_result_t;

    // hi - lo, clamped at zero
    function automatic coord_t span(input coord_t lo, input coord_t hi);
        span = (hi > lo) ? coord_t'(hi - lo) : '0;
    endfunction

endpackage

`default_nettype wire

// ----- design/biou_box_if.sv -----
// Input channel carrying one pair of boxes with a valid/ready handshake.
// Depends on biou_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface biou_box_if;
    logic            valid;
    logic            ready;
    biou_pkg::coord_t a_xmin;
    biou_pkg::coord_t a_ymin;
    biou_pkg::coord_t a_xmax;
    biou_pkg::coord_t a_ymax;
    biou_pkg::coord_t b_xmin;
    biou_pkg::coord_t b_ymin;
    biou_pkg::coord_t b_xmax;
    biou_pkg::coord_t b_ymax;

    modport source (
        output valid, a_xmin, a_ymin, a_xmax, a_ymax, b_xmin, b_ymin, b_xmax, b_ymax,
        input  ready
    );
    modport sink (
        input  valid, a_xmin, a_ymin, a_xmax, a_ymax, b_xmin, b_ymin, b_xmax, b_ymax,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/biou_ratio_if.sv -----
// Output channel carrying the overlap ratio and empty-union flag.
// Depends on biou_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface biou_ratio_if;
    logic            valid;
    logic            ready;
    biou_pkg::ratio_t overlap_ratio;
    logic            empty_union;

    modport source (output valid, overlap_ratio, empty_union, input ready);
    modport sink   (input  valid, overlap_ratio, empty_union, output ready);
endinterface

`default_nettype wire

// ----- design/box_intersection_over_union_unit.sv -----
// Top level of the box intersection-over-union unit: front end, divider
// and output register. Depends on biou_pkg, biou_box_if, biou_ratio_if,
// biou_front and biou_div.
`timescale 1ns / 1ps
`default_nettype none

// Intersection over union of two axis-aligned boxes. Each transfer on
// "boxes" carries both boxes as xmin, ymin, xmax, ymax; a box with a max
// edge below its min edge has zero area. Each transfer produces exactly one
// transfer on "ratio": overlap_ratio = floor(intersection * 65536 / union),
// 17 bits, 65536 meaning 1.0. When both areas are zero the ratio reads 0
// and empty_union is set. The unit takes one pair per clock while
// boxes.ready is high; each pair passes through the register stages for
// spans, areas and union, then the one-bit-per-stage divider stages and
// then the output register. Every stage holds its own valid bit, so
// a stalled consumer fills empty stages first and back-pressure reaches
// the input only once the pipeline is full. No configuration, no state
// between items.

module box_intersection_over_union_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    biou_box_if.sink     boxes,
    biou_ratio_if.source ratio
);

    biou_pkg::div_operand_t opnd;
    logic                   opnd_valid;
    logic                   opnd_ready;
    biou_pkg::div_result_t  res;
    logic                   res_valid;
    logic                   res_ready;

    biou_pkg::ratio_t       ratio_reg, ratio_next;
    logic                   empty_reg, empty_next;
    logic                   out_valid_reg;

    // Spans, products and union
    biou_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .boxes      (boxes),
        .opnd       (opnd),
        .opnd_valid (opnd_valid),
        .opnd_ready (opnd_ready)
    );

    // Quotient, one bit per stage
    biou_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .opnd       (opnd),
        .opnd_valid (opnd_valid),
        .opnd_ready (opnd_ready),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready)
    );

    // Advance the output register when it is empty or its transfer completes
    assign res_ready = !out_valid_reg || ratio.ready;

    // Drop the divider's quotient when the union is empty: 0/0 reads as 0
    always_comb
    begin
        ratio_next = res.empty ? '0 : res.quot;
        empty_next = res.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready)
        begin
            ratio_reg <= ratio_next;
            empty_reg <= empty_next;
        end
    end

    assign ratio.valid         = out_valid_reg;
    assign ratio.overlap_ratio = ratio_reg;
    assign ratio.empty_union   = empty_reg;

endmodule

`default_nettype wire

// ----- design/biou_front.sv -----
// Front end: spans, areas and union in three register stages.
// Depends on biou_pkg and biou_box_if.
`timescale 1ns / 1ps
`default_nettype none

module biou_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    biou_box_if.sink                    boxes,
    output biou_pkg::div_operand_t      opnd,
    output logic                        opnd_valid,
    input  wire logic                   opnd_ready
);

    biou_pkg::span_set_t    span_reg,  span_next;
    biou_pkg::area_set_t    area_reg,  area_next;
    biou_pkg::div_operand_t opnd_reg,  opnd_next;
    logic                   v1_reg, v2_reg, v3_reg;
    logic                   en1, en2, en3;

    // A stage advances when it is empty or its successor advances
    assign en3 = !v3_reg || opnd_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign boxes.ready = en1;

    // Stage 1: clamped spans
    always_comb
    begin
        span_next.iw = biou_pkg::span(
            (boxes.a_xmin > boxes.b_xmin) ? boxes.a_xmin : boxes.b_xmin,
            (boxes.a_xmax < boxes.b_xmax) ? boxes.a_xmax : boxes.b_xmax);
        span_next.ih = biou_pkg::span(
            (boxes.a_ymin > boxes.b_ymin) ? boxes.a_ymin : boxes.b_ymin,
            (boxes.a_ymax < boxes.b_ymax) ? boxes.a_ymax : boxes.b_ymax);
        span_next.wa = biou_pkg::span(boxes.a_xmin, boxes.a_xmax);
        span_next.ha = biou_pkg::span(boxes.a_ymin, boxes.a_ymax);
        span_next.wb = biou_pkg::span(boxes.b_xmin, boxes.b_xmax);
        span_next.hb = biou_pkg::span(boxes.b_ymin, boxes.b_ymax);
    end

    // Stage 2: three narrow products
    always_comb
    begin
        area_next.inter  = biou_pkg::area_t'(span_reg.iw * span_reg.ih);
        area_next.area_a = biou_pkg::area_t'(span_reg.wa * span_reg.ha);
        area_next.area_b = biou_pkg::area_t'(span_reg.wb * span_reg.hb);
    end

    // Stage 3: union; zero only when both areas are zero
    always_comb
    begin
        opnd_next.inter = area_reg.inter;
        opnd_next.uni   = biou_pkg::union_t'({1'b0, area_reg.area_a})
                        + biou_pkg::union_t'({1'b0, area_reg.area_b})
                        - biou_pkg::union_t'({1'b0, area_reg.inter});
        opnd_next.empty = (opnd_next.uni == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= boxes.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) span_reg <= span_next;
        if (en2) area_reg <= area_next;
        if (en3) opnd_reg <= opnd_next;
    end

    assign opnd       = opnd_reg;
    assign opnd_valid = v3_reg;

endmodule

`default_nettype wire

// ----- design/biou_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on biou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module biou_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire biou_pkg::div_operand_t opnd,
    input  wire logic                   opnd_valid,
    output logic                        opnd_ready,
    output biou_pkg::div_result_t       res,
    output logic                        res_valid,
    input  wire logic                   res_ready
);

    localparam int N = biou_pkg::DIV_STAGES;
    localparam int W = biou_pkg::UNION_BITS;

    biou_pkg::div_state_t st_reg  [N];
    biou_pkg::div_state_t st_next [N];
    logic [N-1:0]         valid_reg;
    logic [N-1:0]         en;

    assign opnd_ready = en[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [W:0]           trial;
        logic [W:0]           diff;
        logic                 ge;
        biou_pkg::div_state_t prev;

        if (i == N - 1)
        begin : g_last
            assign en[i] = !valid_reg[i] || res_ready;
        end
        else
        begin : g_mid
            assign en[i] = !valid_reg[i] || en[i+1];
        end

        if (i == 0)
        begin : g_first
            // Top bit: the ratio is at most one, so compare without shifting
            always_comb
            begin
                prev.rem   = W'(opnd.inter);
                prev.quot  = '0;
                prev.uni   = opnd.uni;
                prev.empty = opnd.empty;
            end
            assign trial = {1'b0, prev.rem};
        end
        else
        begin : g_rest
            assign prev  = st_reg[i-1];
            assign trial = {prev.rem, 1'b0};
        end

        assign diff = trial - {1'b0, prev.uni};
        assign ge   = (trial >= {1'b0, prev.uni});

        // Remainder stays below the union, so it fits in W bits
        always_comb
        begin
            st_next[i].rem   = ge ? diff[W-1:0] : trial[W-1:0];
            st_next[i].quot  = {prev.quot[biou_pkg::RATIO_BITS-2:0], ge};
            st_next[i].uni   = prev.uni;
            st_next[i].empty = prev.empty;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en[i])
                valid_reg[i] <= (i == 0) ? opnd_valid : valid_reg[(i == 0) ? 0 : i - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
                st_reg[i] <= st_next[i];
        end
    end

    assign res.quot  = st_reg[N-1].quot;
    assign res.empty = st_reg[N-1].empty;
    assign res_valid = valid_reg[N-1];

endmodule

`default_nettype wire
